// File: rtl/pdd_pkg.sv
// ----------------------------------------------------------------------------
// pdd_pkg
// Shared types and constants for the point distance and direction block.
// ----------------------------------------------------------------------------
package pdd_pkg;

	// Width of the fixed-point distance field of a result.
	localparam int DIST_W = 33;

	// Main direction codes.
	typedef enum logic [2:0] {
		DIR_UP    = 3'd0,
		DIR_DOWN  = 3'd1,
		DIR_RIGHT = 3'd2,
		DIR_LEFT  = 3'd3,
		DIR_TIE   = 3'd4,
		DIR_NONE  = 3'd5
	} dir_t;

	// One result as it is held in the output buffer.
	typedef struct packed {
		logic [DIST_W-1:0] dist_fixed;
		dir_t              direction;
	} result_t;

endpackage

// File: rtl/pdd_if.sv
// ----------------------------------------------------------------------------
// pdd_if
// Valid/ready channels: a point pair going in and a distance result coming out.
// ----------------------------------------------------------------------------

// Point pair channel; coordinates are two's complement.
interface pdd_point_if #(
	parameter int CW = 16
) ();
	logic                 valid;
	logic                 ready;
	logic signed [CW-1:0] start_x;
	logic signed [CW-1:0] start_y;
	logic signed [CW-1:0] target_x;
	logic signed [CW-1:0] target_y;

	modport source (output valid, output start_x, output start_y,
		output target_x, output target_y, input ready);
	modport sink (input valid, input start_x, input start_y,
		input target_x, input target_y, output ready);
endinterface

// Result channel: fixed-point distance and main direction code.
interface pdd_result_if ();
	logic                          valid;
	logic                          ready;
	logic [pdd_pkg::DIST_W-1:0]    dist_fixed;
	pdd_pkg::dir_t                 direction;

	modport source (output valid, output dist_fixed, output direction, input ready);
	modport sink (input valid, input dist_fixed, input direction, output ready);
endinterface

// File: rtl/pdd_front.sv
// ----------------------------------------------------------------------------
// pdd_front
// Front pipeline: coordinate differences, magnitudes, squares, sum of squares
// and the main direction code, one transaction per cycle while en is high.
// ----------------------------------------------------------------------------
module pdd_front #(
	parameter int CW   = 16,
	parameter int FB   = 16,
	parameter int OP_W = 2 * (CW + 1 + FB)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	pdd_point_if.sink           points,
	output logic                valid_out,
	output logic [OP_W-1:0]     op_out,
	output pdd_pkg::dir_t       dir_out
);
	import pdd_pkg::*;

	localparam int SUM_W = 2 * CW + 1;

	logic                valid_s1, valid_s2, valid_s3, valid_s4;
	logic [CW:0]         diff_x_s1, diff_y_s1;
	logic [CW:0]         neg_x, neg_y;
	logic [CW-1:0]       mag_x_s2, mag_y_s2;
	logic                left_s2, down_s2;
	logic [2*CW-1:0]     sq_x_s3, sq_y_s3;
	dir_t                dir_s3, dir_s4;
	dir_t                dir_next;
	logic [SUM_W-1:0]    sum_s4;

	// The pipeline only moves when the output side has room.
	assign points.ready = en;

	// Valid bits of the stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s1 <= points.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			valid_s4 <= valid_s3;
		end
	end

	// Two's complement negation of the differences for the magnitudes.
	assign neg_x = ~diff_x_s1 + 1'b1;
	assign neg_y = ~diff_y_s1 + 1'b1;

	// The axis with the larger magnitude decides; a sign picks the side.
	always_comb begin
		if (mag_x_s2 < mag_y_s2) begin
			dir_next = down_s2 ? DIR_DOWN : DIR_UP;
		end else if (mag_x_s2 > mag_y_s2) begin
			dir_next = left_s2 ? DIR_LEFT : DIR_RIGHT;
		end else if (mag_x_s2 != '0) begin
			dir_next = DIR_TIE;
		end else begin
			dir_next = DIR_NONE;
		end
	end

	// Data path of the stages.
	always_ff @(posedge clk) begin
		if (en) begin
			diff_x_s1 <= {points.target_x[CW-1], points.target_x}
				- {points.start_x[CW-1], points.start_x};
			diff_y_s1 <= {points.target_y[CW-1], points.target_y}
				- {points.start_y[CW-1], points.start_y};

			mag_x_s2 <= diff_x_s1[CW] ? neg_x[CW-1:0] : diff_x_s1[CW-1:0];
			mag_y_s2 <= diff_y_s1[CW] ? neg_y[CW-1:0] : diff_y_s1[CW-1:0];
			left_s2  <= diff_x_s1[CW];
			down_s2  <= diff_y_s1[CW];

			sq_x_s3 <= mag_x_s2 * mag_x_s2;
			sq_y_s3 <= mag_y_s2 * mag_y_s2;
			dir_s3  <= dir_next;

			sum_s4 <= {1'b0, sq_x_s3} + {1'b0, sq_y_s3};
			dir_s4 <= dir_s3;
		end
	end

	// The root operand is the sum scaled by the square of the fraction weight.
	assign valid_out = valid_s4;
	assign op_out    = OP_W'(sum_s4) << (2 * FB);
	assign dir_out   = dir_s4;

endmodule

// File: rtl/pdd_root_cell.sv
// ----------------------------------------------------------------------------
// pdd_root_cell
// One cell of the square root chain: takes the next two operand bits, tries
// the next root bit and hands remainder, partial root and operand onward.
// ----------------------------------------------------------------------------
module pdd_root_cell #(
	parameter int ROOT_W = 33,
	parameter int OP_W   = 2 * ROOT_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                valid_in,
	input  logic [OP_W-1:0]     op_in,
	input  logic [ROOT_W+1:0]   rem_in,
	input  logic [ROOT_W-1:0]   root_in,
	input  pdd_pkg::dir_t       dir_in,
	output logic                valid_out,
	output logic [OP_W-1:0]     op_out,
	output logic [ROOT_W+1:0]   rem_out,
	output logic [ROOT_W-1:0]   root_out,
	output pdd_pkg::dir_t       dir_out
);
	import pdd_pkg::*;

	logic              valid_q;
	logic [OP_W-1:0]   op_q;
	logic [ROOT_W+1:0] rem_q;
	logic [ROOT_W-1:0] root_q;
	dir_t              dir_q;

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic [ROOT_W+2:0] diff;
	logic              fits;

	// Bring down two operand bits and compare against 4*root + 1.
	assign rem_sh = {rem_in[ROOT_W-1:0], op_in[OP_W-1 -: 2]};
	assign trial  = {root_in, 2'b01};
	assign diff   = {1'b0, rem_sh} - {1'b0, trial};
	assign fits   = !diff[ROOT_W+2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_q   <= {op_in[OP_W-3:0], 2'b00};
			rem_q  <= fits ? diff[ROOT_W+1:0] : rem_sh;
			root_q <= {root_in[ROOT_W-2:0], fits};
			dir_q  <= dir_in;
		end
	end

	assign valid_out = valid_q;
	assign op_out    = op_q;
	assign rem_out   = rem_q;
	assign root_out  = root_q;
	assign dir_out   = dir_q;

endmodule

// File: rtl/pdd_out_buf.sv
// ----------------------------------------------------------------------------
// pdd_out_buf
// Output register with a skid register behind it; the pipeline stalls only
// while the skid register holds a result.
// ----------------------------------------------------------------------------
module pdd_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  pdd_pkg::result_t    in_data,
	output logic                pipe_en,
	pdd_result_if.source        result
);
	import pdd_pkg::*;

	logic    out_valid_q;
	logic    skid_full_q;
	result_t out_q;
	result_t skid_q;
	logic    take;
	logic    drain;
	logic    load_out;
	logic    load_skid;

	// A result from the chain only counts while the chain is moving.
	assign pipe_en   = !skid_full_q;
	assign take      = in_valid && !skid_full_q;
	assign drain     = out_valid_q && result.ready;
	assign load_out  = (drain && skid_full_q) || (take && (drain || !out_valid_q));
	assign load_skid = take && out_valid_q && !drain;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_full_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (drain) begin
				out_valid_q <= 1'b0;
			end
			if (load_skid) begin
				skid_full_q <= 1'b1;
			end else if (drain) begin
				skid_full_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_q <= skid_full_q ? skid_q : in_data;
		end
		if (load_skid) begin
			skid_q <= in_data;
		end
	end

	assign result.valid      = out_valid_q;
	assign result.dist_fixed = out_q.dist_fixed;
	assign result.direction  = out_q.direction;

endmodule

// File: rtl/point_distance_direction.sv
// ----------------------------------------------------------------------------
// point_distance_direction
// Euclidean distance in fixed point and main direction between two points.
// ----------------------------------------------------------------------------
// Each transaction carries a start and a target point; the block returns
// floor(sqrt(dx*dx + dy*dy)) with FRAC_BITS fraction bits (low 33 bits kept)
// and a direction code. It takes one transaction per cycle while ready is
// high. After its point pair is accepted, a result passes these register
// stages in order: four front stages form the differences, magnitudes,
// squares and sum, a chain of COORD_WIDTH + FRAC_BITS + 1 root cells
// settles one root bit each, and an output register presents the result.
// A skid register behind the output register lets one more result land
// while the output is stalled; ready drops only while it is occupied.
// ----------------------------------------------------------------------------
module point_distance_direction #(
	parameter int COORD_WIDTH = 16,
	parameter int FRAC_BITS   = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	pdd_point_if.sink     points,
	pdd_result_if.source  result
);
	import pdd_pkg::*;

	localparam int ROOT_W = COORD_WIDTH + 1 + FRAC_BITS;
	localparam int OP_W   = 2 * ROOT_W;

	logic              en;
	logic              valid_c [0:ROOT_W];
	logic [OP_W-1:0]   op_c    [0:ROOT_W];
	logic [ROOT_W+1:0] rem_c   [0:ROOT_W];
	logic [ROOT_W-1:0] root_c  [0:ROOT_W];
	dir_t              dir_c   [0:ROOT_W];
	result_t           res_d;

	// Differences, squares, sum and direction.
	pdd_front #(
		.CW   (COORD_WIDTH),
		.FB   (FRAC_BITS),
		.OP_W (OP_W)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.points    (points),
		.valid_out (valid_c[0]),
		.op_out    (op_c[0]),
		.dir_out   (dir_c[0])
	);

	// The root starts from zero remainder and zero partial root.
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;

	// Square root chain, one result bit per cell.
	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		pdd_root_cell #(
			.ROOT_W (ROOT_W),
			.OP_W   (OP_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (valid_c[i]),
			.op_in     (op_c[i]),
			.rem_in    (rem_c[i]),
			.root_in   (root_c[i]),
			.dir_in    (dir_c[i]),
			.valid_out (valid_c[i+1]),
			.op_out    (op_c[i+1]),
			.rem_out   (rem_c[i+1]),
			.root_out  (root_c[i+1]),
			.dir_out   (dir_c[i+1])
		);
	end

	// The distance field keeps the low bits of the root.
	assign res_d.dist_fixed = DIST_W'(root_c[ROOT_W]);
	assign res_d.direction  = dir_c[ROOT_W];

	pdd_out_buf u_out_buf (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (valid_c[ROOT_W]),
		.in_data  (res_d),
		.pipe_en  (en),
		.result   (result)
	);

endmodule
